@@ hw/rtl/arpcr_pkg.sv @@
`timescale 1ns / 1ps
package arpcr_pkg;

  localparam logic [15:0] OP_REQUEST = 16'h0100;
  localparam logic [15:0] OP_REPLY   = 16'h0200;

  localparam logic [2:0] ACT_IGNORED = 3'd0;
  localparam logic [2:0] ACT_CACHED  = 3'd1;
  localparam logic [2:0] ACT_REPLY   = 3'd2;
  localparam logic [2:0] ACT_HIT     = 3'd3;
  localparam logic [2:0] ACT_MISS    = 3'd4;

  localparam logic REG_OWN_MAC = 1'b0;
  localparam logic REG_OWN_IP  = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef struct packed {
    logic        mode;
    logic [15:0] operation;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] query_ip;
  } arp_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [47:0] resolved_mac;
  } arp_out_t;

  typedef enum logic [1:0] {
    CMD_IGNORE,
    CMD_CACHE,
    CMD_REPLY,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_RES
  } back_state_t;

endpackage

@@ hw/rtl/arpcr_front.sv @@
`timescale 1ns / 1ps
module arpcr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  arpcr_pkg::arp_in_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output arpcr_pkg::cmd_t  cmd_data
);
  import arpcr_pkg::*;

  logic cmd_next_valid;
  cmd_t cmd_class;

  always_comb begin
    cmd_class.mac  = '0;
    cmd_class.ip   = in_data.sender_ip;
    cmd_class.kind = CMD_IGNORE;
    if (in_data.mode) begin
      cmd_class.kind = CMD_LOOKUP;
      cmd_class.ip   = in_data.query_ip;
    end else begin
      case (in_data.operation)
        OP_REQUEST: begin
          cmd_class.kind = CMD_REPLY;
          cmd_class.mac  = in_data.sender_mac;
        end
        OP_REPLY: begin
          cmd_class.kind = CMD_CACHE;
          cmd_class.mac  = in_data.sender_mac;
        end
        default: begin
          cmd_class.kind = CMD_IGNORE;
          cmd_class.ip   = '0;
        end
      endcase
    end
  end

  assign in_ready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next_valid = cmd_valid && !cmd_ready;
    if (in_valid && in_ready) begin
      cmd_next_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= cmd_next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_data <= cmd_class;
    end
  end

endmodule

@@ hw/rtl/arpcr_queue.sv @@
`timescale 1ns / 1ps
module arpcr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  arpcr_pkg::cmd_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output arpcr_pkg::cmd_t pop_data
);
  import arpcr_pkg::*;

  cmd_t             slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != QCW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hw/rtl/arpcr_back.sv @@
`timescale 1ns / 1ps
module arpcr_back #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  arpcr_pkg::cmd_t     cmd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output arpcr_pkg::arp_out_t out_data
);
  import arpcr_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0]   ip_mem  [ENTRIES];
  logic [47:0]   mac_mem [ENTRIES];
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;

  back_state_t   state, state_next;
  logic [IW-1:0] wptr, wptr_next;
  logic [CW-1:0] filled, filled_next;
  logic [CW-1:0] idx, idx_next;
  logic          pend, pend_next;
  logic [31:0]   lk_ip, lk_ip_next;
  arp_out_t      res, res_next;
  logic          out_valid_next;
  arp_out_t      out_data_next;
  logic          wr_en;

  always_comb begin
    state_next     = state;
    wptr_next      = wptr;
    filled_next    = filled;
    idx_next       = idx;
    pend_next      = pend;
    lk_ip_next     = lk_ip;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    cmd_ready      = 1'b0;
    wr_en          = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          res_next  = '0;
          case (cmd_data.kind)
            CMD_REPLY: begin
              res_next.action     = ACT_REPLY;
              res_next.target_mac = cmd_data.mac;
              res_next.target_ip  = cmd_data.ip;
              state_next          = B_RES;
            end
            CMD_CACHE: begin
              wr_en           = 1'b1;
              wptr_next       = (wptr == IW'(ENTRIES - 1)) ? '0 : wptr + 1'b1;
              if (filled != CW'(ENTRIES)) begin
                filled_next = filled + 1'b1;
              end
              res_next.action = ACT_CACHED;
              state_next      = B_RES;
            end
            CMD_LOOKUP: begin
              lk_ip_next = cmd_data.ip;
              idx_next   = '0;
              pend_next  = 1'b0;
              state_next = B_SCAN;
            end
            default: begin
              res_next.action = ACT_IGNORED;
              state_next      = B_RES;
            end
          endcase
        end
      end
      B_SCAN: begin
        if (pend && (rd_ip == lk_ip)) begin
          res_next              = '0;
          res_next.action       = ACT_HIT;
          res_next.resolved_mac = rd_mac;
          state_next            = B_RES;
        end else if (idx < filled) begin
          idx_next  = idx + 1'b1;
          pend_next = 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          res_next           = '0;
          res_next.action    = ACT_MISS;
          res_next.target_ip = lk_ip;
          state_next         = B_RES;
        end
      end
      B_RES: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wptr      <= '0;
      filled    <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wptr      <= wptr_next;
      filled    <= filled_next;
      idx       <= idx_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lk_ip    <= lk_ip_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  // cache memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wptr]  <= cmd_data.ip;
      mac_mem[wptr] <= cmd_data.mac;
    end
    rd_ip  <= ip_mem[idx[IW-1:0]];
    rd_mac <= mac_mem[idx[IW-1:0]];
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= CW'(ENTRIES))
    else $error("filled count above cache size");

  a_wptr_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (filled != CW'(ENTRIES)) |-> (CW'(wptr) == filled))
    else $error("write pointer out of step with fill count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> (idx <= filled))
    else $error("scan index past filled entries");

  a_cache_only_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == B_IDLE))
    else $error("cache write outside idle");

  a_hit_has_match: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN && state_next == B_RES && res_next.action == ACT_HIT)
      |-> (pend && rd_ip == lk_ip))
    else $error("hit without matching entry");

endmodule

@@ hw/rtl/arp_cache_responder.sv @@
`timescale 1ns / 1ps
// channel  | handshake                       | payload
// ---------+---------------------------------+---------------------------
// in       | in_valid / in_ready             | in_data  (arp_in_t)
// out      | out_valid / out_ready           | out_data (arp_out_t)
// config   | psel penable pwrite / pready=1  | paddr pwdata / prdata
//
// packet items pass the front register, a queue slot and the back result register on the way to the output register
// a lookup reads the filled cache entries one per cycle in the back scan and stops at the first match
// front register and a 2-entry queue keep taking items while the back scans
// reset clears control state, pointers and fill count; cache contents need no clearing
module arp_cache_responder #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  arpcr_pkg::arp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output arpcr_pkg::arp_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import arpcr_pkg::*;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic        f_valid, f_ready;
  cmd_t        f_data;
  logic        q_valid, q_ready;
  cmd_t        q_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip  <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        REG_OWN_MAC: own_mac <= pwdata[47:0];
        REG_OWN_IP:  own_ip  <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_OWN_MAC: prdata = {16'h0, own_mac};
      REG_OWN_IP:  prdata = {32'h0, own_ip};
      default:     prdata = '0;
    endcase
  end

  arpcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  arpcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  arpcr_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
